>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the Euler angle block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that a property holds at every clock edge outside reset.
`define EAB_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
// Check that a condition implies another one in the same cycle.
`define EAB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Check that a condition implies another one in the next cycle.
`define EAB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define EAB_ASSERT(lbl, clk, rst_n, prop)
`define EAB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define EAB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/core/eab_pkg.sv
// Shared constants, types and the sine table builder of the Euler angle block.
package eab_pkg;

	localparam int ANGLE_BITS_DEF = 12;
	localparam int FRAC_BITS_DEF  = 14;
	localparam int OUT_W          = 16;

	// pi/2 in unsigned Q2.62
	localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

	// per-stage advance enables handed to the sine/cosine unit
	typedef struct packed {
		logic s1;
		logic s2;
	} eab_adv_t;

	// Sine of idx/2^qshift of a quarter turn, rounded to frac fraction bits.
	// Taylor series in Q62, evaluated at elaboration to fill the table.
	function automatic logic [63:0] sin_entry(input int unsigned idx,
		input int unsigned qshift, input int unsigned frac);
		logic [127:0] prod;
		logic [63:0]  x;
		logic [63:0]  x2;
		logic [63:0]  term;
		logic [63:0]  acc;
		int unsigned  k;
		prod = 128'(HALF_PI_Q62) * 128'(idx);
		x    = 64'(prod >> qshift);
		prod = 128'(x) * 128'(x);
		x2   = 64'(prod >> 62);
		term = x;
		acc  = x;
		for (k = 1; k <= 13; k++) begin
			prod = 128'(term) * 128'(x2);
			term = 64'(prod >> 62) / 64'((2 * k) * (2 * k + 1));
			if (k[0]) begin
				acc = acc - term;
			end else begin
				acc = acc + term;
			end
		end
		acc = acc + (64'd1 << (61 - frac));
		return acc >> (62 - frac);
	endfunction

endpackage

>>> rtl/core/eab_sincos.sv
// Sine and cosine of one binary angle from a quarter-wave table, two stages.
module eab_sincos #(
	parameter int ANGLE_BITS = eab_pkg::ANGLE_BITS_DEF,
	parameter int FRAC_BITS  = eab_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  eab_pkg::eab_adv_t            adv,
	input  logic [ANGLE_BITS-1:0]        angle,
	output logic signed [FRAC_BITS+1:0]  sin_val,
	output logic signed [FRAC_BITS+1:0]  cos_val
);
	import eab_pkg::*;

	localparam int QS      = ANGLE_BITS - 2;
	localparam int QUARTER = 1 << QS;
	localparam logic [QS:0] QUARTER_IDX = {1'b1, {QS{1'b0}}};

	logic [FRAC_BITS:0] rom [0:QUARTER];

	logic [1:0]    sin_quad;
	logic [1:0]    cos_quad;
	logic [QS-1:0] resid;
	logic [QS:0]   sin_idx;
	logic [QS:0]   cos_idx;

	logic [QS:0]        sin_idx_s1;
	logic [QS:0]        cos_idx_s1;
	logic               sin_neg_s1;
	logic               cos_neg_s1;
	logic [FRAC_BITS:0] sin_mag_s2;
	logic [FRAC_BITS:0] cos_mag_s2;
	logic               sin_neg_s2;
	logic               cos_neg_s2;
	logic signed [FRAC_BITS+1:0] sin_pos;
	logic signed [FRAC_BITS+1:0] cos_pos;

	// build the quarter-wave table, one entry per step including the full quarter
	for (genvar i = 0; i <= QUARTER; i++) begin : g_rom
		localparam logic [63:0] ENTRY = sin_entry(i, QS, FRAC_BITS);
		assign rom[i] = ENTRY[FRAC_BITS:0];
	end

	// fold the angle into the first quadrant; cosine is one quadrant ahead
	always_comb begin
		sin_quad = angle[ANGLE_BITS-1:ANGLE_BITS-2];
		cos_quad = sin_quad + 2'd1;
		resid    = angle[QS-1:0];
		sin_idx  = sin_quad[0] ? QUARTER_IDX - {1'b0, resid} : {1'b0, resid};
		cos_idx  = cos_quad[0] ? QUARTER_IDX - {1'b0, resid} : {1'b0, resid};
	end

	// hold the table addresses and signs
	always_ff @(posedge clk) begin
		if (adv.s1) begin
			sin_idx_s1 <= sin_idx;
			cos_idx_s1 <= cos_idx;
			sin_neg_s1 <= sin_quad[1];
			cos_neg_s1 <= cos_quad[1];
		end
	end

	// registered table read at two addresses
	always_ff @(posedge clk) begin
		if (adv.s2) begin
			sin_mag_s2 <= rom[sin_idx_s1];
			cos_mag_s2 <= rom[cos_idx_s1];
			sin_neg_s2 <= sin_neg_s1;
			cos_neg_s2 <= cos_neg_s1;
		end
	end

	// apply the quadrant sign
	always_comb begin
		sin_pos = signed'({1'b0, sin_mag_s2});
		cos_pos = signed'({1'b0, cos_mag_s2});
		sin_val = sin_neg_s2 ? -sin_pos : sin_pos;
		cos_val = cos_neg_s2 ? -cos_pos : cos_pos;
	end

endmodule

>>> rtl/core/euler_angles_to_basis_vectors_top.sv
// Top level: yaw, pitch and roll to forward, right and up vectors.
//
//  channel | handshake          | word
//  --------+--------------------+-------------------------------------------
//  in      | in_valid, in_stall | yaw_angle, pitch_angle, roll_angle
//  out     | out_valid, out_stall | fwd_*, right_*, up_* (signed Q1.FRAC_BITS)
//
// One word per cycle while in_stall is low; each word passes the stages of table address,
// sine table read, pair products, split triple products, sums, round/saturate.
// Each angle has its own table of 2^(ANGLE_BITS-2)+1 entries read at two ports.
// Reset clears only the stage valid bits; the table is constant.
// A stage holds only while the stage after it is full and holding, so bubbles
// close up and a word is taken while a finished result waits at the output.
module euler_angles_to_basis_vectors_top #(
	parameter int ANGLE_BITS = eab_pkg::ANGLE_BITS_DEF,
	parameter int FRAC_BITS  = eab_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [ANGLE_BITS-1:0]       yaw_angle,
	input  logic [ANGLE_BITS-1:0]       pitch_angle,
	input  logic [ANGLE_BITS-1:0]       roll_angle,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [eab_pkg::OUT_W-1:0] fwd_x,
	output logic signed [eab_pkg::OUT_W-1:0] fwd_y,
	output logic signed [eab_pkg::OUT_W-1:0] fwd_z,
	output logic signed [eab_pkg::OUT_W-1:0] right_x,
	output logic signed [eab_pkg::OUT_W-1:0] right_y,
	output logic signed [eab_pkg::OUT_W-1:0] right_z,
	output logic signed [eab_pkg::OUT_W-1:0] up_x,
	output logic signed [eab_pkg::OUT_W-1:0] up_y,
	output logic signed [eab_pkg::OUT_W-1:0] up_z
);
	import eab_pkg::*;

	`include "assert_macros.svh"

	localparam int VW  = FRAC_BITS + 2;      // sine/cosine value
	localparam int PW  = 2 * FRAC_BITS + 2;  // pair product
	localparam int HW  = FRAC_BITS + 1;      // upper part of a pair product
	localparam int HPW = 2 * FRAC_BITS + 3;  // upper partial product
	localparam int LPW = 2 * FRAC_BITS + 4;  // lower partial product
	localparam int SW  = 3 * FRAC_BITS + 3;  // sum at scale 3F
	localparam int RW  = FRAC_BITS + 3;      // rounded component

	localparam logic signed [SW-1:0] RND_HALF =
		{{(SW - 2 * FRAC_BITS){1'b0}}, 1'b1, {(2 * FRAC_BITS - 1){1'b0}}};
	localparam logic signed [RW-1:0] ONE_FX = {3'b001, {FRAC_BITS{1'b0}}};
	localparam logic signed [RW-1:0] NEG_ONE_FX = -ONE_FX;

	// stage valid bits and advance enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6;
	eab_adv_t yaw_adv;

	logic signed [VW-1:0] sy, cy, sp, cp, sr, cr;

	// stage 3: pair products
	logic signed [PW-1:0] cpcy_s3, cpsy_s3, srcp_s3, crcp_s3;
	logic signed [PW-1:0] srsp_s3, crsp_s3, crsy_s3, crcy_s3, srsy_s3, srcy_s3;
	logic signed [VW-1:0] sp_s3, cy_s3, sy_s3;

	// stage 4: split triple products and carried pair products
	logic signed [HPW-1:0] thi_s4 [4];
	logic signed [LPW-1:0] tlo_s4 [4];
	logic signed [PW-1:0]  cpcy_s4, cpsy_s4, srcp_s4, crcp_s4;
	logic signed [PW-1:0]  crsy_s4, crcy_s4, srsy_s4, srcy_s4;
	logic signed [VW-1:0]  sp_s4;

	logic signed [HW-1:0]  srsp_hi, crsp_hi;
	logic signed [VW-1:0]  srsp_lo, crsp_lo;

	// stage 5: component sums, stage 6: output words
	logic signed [SW-1:0]    tri_c [4];
	logic signed [SW-1:0]    sum_c [9];
	logic signed [SW-1:0]    sum_s5 [9];
	logic signed [SW-1:0]    rnd_full [9];
	logic signed [RW-1:0]    rnd [9];
	logic signed [RW-1:0]    sat [9];
	logic signed [OUT_W-1:0] out_s6 [9];

	// a stage moves when it is empty or the next stage moves
	always_comb begin
		en6 = !v_s6 || !out_stall;
		en5 = !v_s5 || en6;
		en4 = !v_s4 || en5;
		en3 = !v_s3 || en4;
		en2 = !v_s2 || en3;
		en1 = !v_s1 || en2;
		in_stall = !en1;
		yaw_adv.s1 = en1;
		yaw_adv.s2 = en2;
	end

	// advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	// stages 1 and 2: sine and cosine of each angle
	eab_sincos #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_yaw (
		.clk(clk), .adv(yaw_adv), .angle(yaw_angle), .sin_val(sy), .cos_val(cy)
	);
	eab_sincos #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_pitch (
		.clk(clk), .adv(yaw_adv), .angle(pitch_angle), .sin_val(sp), .cos_val(cp)
	);
	eab_sincos #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_roll (
		.clk(clk), .adv(yaw_adv), .angle(roll_angle), .sin_val(sr), .cos_val(cr)
	);

	// stage 3: the ten products of two factors that the components use
	always_ff @(posedge clk) begin
		if (en3) begin
			cpcy_s3 <= PW'(cp) * PW'(cy);
			cpsy_s3 <= PW'(cp) * PW'(sy);
			srcp_s3 <= PW'(sr) * PW'(cp);
			crcp_s3 <= PW'(cr) * PW'(cp);
			srsp_s3 <= PW'(sr) * PW'(sp);
			crsp_s3 <= PW'(cr) * PW'(sp);
			crsy_s3 <= PW'(cr) * PW'(sy);
			crcy_s3 <= PW'(cr) * PW'(cy);
			srsy_s3 <= PW'(sr) * PW'(sy);
			srcy_s3 <= PW'(sr) * PW'(cy);
			sp_s3   <= sp;
			cy_s3   <= cy;
			sy_s3   <= sy;
		end
	end

	// split the roll-pitch products into a signed upper and an unsigned lower part
	always_comb begin
		srsp_hi = srsp_s3[PW-1:FRAC_BITS+1];
		crsp_hi = crsp_s3[PW-1:FRAC_BITS+1];
		srsp_lo = signed'({1'b0, srsp_s3[FRAC_BITS:0]});
		crsp_lo = signed'({1'b0, crsp_s3[FRAC_BITS:0]});
	end

	// stage 4: partial products of the three-factor terms
	always_ff @(posedge clk) begin
		if (en4) begin
			thi_s4[0] <= HPW'(srsp_hi) * HPW'(cy_s3);
			thi_s4[1] <= HPW'(srsp_hi) * HPW'(sy_s3);
			thi_s4[2] <= HPW'(crsp_hi) * HPW'(cy_s3);
			thi_s4[3] <= HPW'(crsp_hi) * HPW'(sy_s3);
			tlo_s4[0] <= LPW'(srsp_lo) * LPW'(cy_s3);
			tlo_s4[1] <= LPW'(srsp_lo) * LPW'(sy_s3);
			tlo_s4[2] <= LPW'(crsp_lo) * LPW'(cy_s3);
			tlo_s4[3] <= LPW'(crsp_lo) * LPW'(sy_s3);
			cpcy_s4 <= cpcy_s3;
			cpsy_s4 <= cpsy_s3;
			srcp_s4 <= srcp_s3;
			crcp_s4 <= crcp_s3;
			crsy_s4 <= crsy_s3;
			crcy_s4 <= crcy_s3;
			srsy_s4 <= srsy_s3;
			srcy_s4 <= srcy_s3;
			sp_s4   <= sp_s3;
		end
	end

	// combine partial products and form every component at scale 3F
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			tri_c[i] = (SW'(thi_s4[i]) <<< (FRAC_BITS + 1)) + SW'(tlo_s4[i]);
		end
		sum_c[0] = SW'(cpcy_s4) <<< FRAC_BITS;
		sum_c[1] = SW'(cpsy_s4) <<< FRAC_BITS;
		sum_c[2] = -(SW'(sp_s4) <<< (2 * FRAC_BITS));
		sum_c[3] = (SW'(crsy_s4) <<< FRAC_BITS) - tri_c[0];
		sum_c[4] = -tri_c[1] - (SW'(crcy_s4) <<< FRAC_BITS);
		sum_c[5] = -(SW'(srcp_s4) <<< FRAC_BITS);
		sum_c[6] = tri_c[2] + (SW'(srsy_s4) <<< FRAC_BITS);
		sum_c[7] = tri_c[3] - (SW'(srcy_s4) <<< FRAC_BITS);
		sum_c[8] = SW'(crcp_s4) <<< FRAC_BITS;
	end

	// stage 5: hold the sums
	always_ff @(posedge clk) begin
		if (en5) begin
			for (int i = 0; i < 9; i++) begin
				sum_s5[i] <= sum_c[i];
			end
		end
	end

	// round half up once, then clamp to +-1.0
	always_comb begin
		for (int i = 0; i < 9; i++) begin
			rnd_full[i] = (sum_s5[i] + RND_HALF) >>> (2 * FRAC_BITS);
			rnd[i]      = RW'(rnd_full[i]);
			if (rnd[i] > ONE_FX) begin
				sat[i] = ONE_FX;
			end else if (rnd[i] < NEG_ONE_FX) begin
				sat[i] = NEG_ONE_FX;
			end else begin
				sat[i] = rnd[i];
			end
		end
	end

	// stage 6: output register
	always_ff @(posedge clk) begin
		if (en6) begin
			for (int i = 0; i < 9; i++) begin
				out_s6[i] <= OUT_W'(sat[i]);
			end
		end
	end

	assign out_valid = v_s6;
	assign fwd_x   = out_s6[0];
	assign fwd_y   = out_s6[1];
	assign fwd_z   = out_s6[2];
	assign right_x = out_s6[3];
	assign right_y = out_s6[4];
	assign right_z = out_s6[5];
	assign up_x    = out_s6[6];
	assign up_y    = out_s6[7];
	assign up_z    = out_s6[8];

	// input backs up only when the whole pipe is full behind a held output
	`EAB_ASSERT_IMPL(a_stall_only_full, clk, arst_n, in_stall,
		v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && out_valid && out_stall)
	// an accepted word lands in the first stage
	`EAB_ASSERT_NEXT(a_accept_enters, clk, arst_n, in_valid && !in_stall, v_s1)
	// no result appears without a word behind it
	`EAB_ASSERT_NEXT(a_no_invented, clk, arst_n, !out_valid && !v_s5, !out_valid)

endmodule
